### design/dtc_pkg.sv
// Shared types and codes for the divider/timer/counter block.
// Used by dtc_core and divider_timer_counter; depends on nothing.
`default_nettype none

package dtc_pkg;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] REG_DIV  = 2'd0;
    localparam logic [1:0] REG_TIMA = 2'd1;
    localparam logic [1:0] REG_TMA  = 2'd2;
    localparam logic [1:0] REG_TAC  = 2'd3;

    localparam logic [1:0] STAGE_OFF   = 2'd0;
    localparam logic [1:0] STAGE_DELAY = 2'd1;
    localparam logic [1:0] STAGE_NOW   = 2'd2;

    localparam logic [15:0] TICK_INCREMENT = 16'd4;
    localparam logic [4:0]  TAC_READ_ONES  = 5'b11111;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] register_select;
        logic [7:0] write_data;
    } request_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       reload_irq;
    } result_t;

    // Counter bit watched by the timer: bit 9, 3, 5 or 7 for rates 0 to 3.
    function automatic logic sel_bit(input logic [15:0] counter, input logic [1:0] rate);
        logic b;
        begin
            case (rate)
                2'd0: b = counter[9];
                2'd1: b = counter[3];
                2'd2: b = counter[5];
                2'd3: b = counter[7];
                default: b = 1'b0;
            endcase
            return b;
        end
    endfunction

endpackage

`default_nettype wire

### design/divider_timer_counter.sv
// Top level of the divider/timer/counter: input register, core, result register.
// Depends on dtc_pkg and dtc_core.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  operation, register_select, write_data
// out      output     out_valid/out_ready  read_data, reload_irq
//
// Each request is held in the input register, then passes through the core into
// the result register. A new request is accepted every cycle while the result
// side keeps up. When out_ready is low with a result waiting, both stages hold
// and in_ready drops once the input register is full.
// Reset clears the timer state and both stage valid flags.
`default_nettype none

module divider_timer_counter
    import dtc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire logic [1:0] operation,
    input  wire logic [1:0] register_select,
    input  wire logic [7:0] write_data,
    output      logic       out_valid,
    input  wire logic       out_ready,
    output      logic [7:0] read_data,
    output      logic       reload_irq
);

    logic     req_valid_reg;
    request_t req_reg;
    logic     res_valid_reg;
    result_t  res_reg;
    result_t  core_res;
    logic     advance;

    assign advance  = req_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    dtc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .enable (advance),
        .req    (req_reg),
        .res    (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                req_valid_reg <= in_valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (out_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            req_reg <= '{operation: operation, register_select: register_select,
                         write_data: write_data};
        if (advance)
            res_reg <= core_res;
    end

    assign out_valid  = res_valid_reg;
    assign read_data  = res_reg.read_data;
    assign reload_irq = res_reg.reload_irq;

endmodule

`default_nettype wire

### design/dtc_core.sv
// Timer state registers and the single-pass update for one request.
// Depends on dtc_pkg.
`default_nettype none

module dtc_core
    import dtc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     enable,
    input  wire request_t req,
    output result_t       res
);

    logic [15:0] counter_reg, counter_next;
    logic        enable_reg, enable_next;
    logic [1:0]  rate_reg, rate_next;
    logic [1:0]  stage_reg, stage_next;
    logic [7:0]  tima_reg, tima_next;
    logic [7:0]  tma_reg, tma_next;

    always_comb
    begin
        logic        step;
        logic [15:0] sum;
        logic        new_en;
        logic [1:0]  new_rate;
        counter_next = counter_reg;
        enable_next  = enable_reg;
        rate_next    = rate_reg;
        stage_next   = stage_reg;
        tima_next    = tima_reg;
        tma_next     = tma_reg;
        res          = '0;
        step         = 1'b0;
        sum          = counter_reg + TICK_INCREMENT;
        new_en       = req.write_data[2];
        new_rate     = req.write_data[1:0];

        case (req.operation)
            OP_TICK:
            begin
                counter_next = sum;
                if (stage_reg == STAGE_DELAY)
                begin
                    stage_next     = STAGE_NOW;
                    tima_next      = tma_reg;
                    res.reload_irq = 1'b1;
                end
                else
                begin
                    stage_next = STAGE_OFF;
                end
                step = enable_reg && sel_bit(counter_reg, rate_reg) && !sel_bit(sum, rate_reg);
            end
            OP_READ:
            begin
                case (req.register_select)
                    REG_DIV:  res.read_data = counter_reg[15:8];
                    REG_TIMA: res.read_data = tima_reg;
                    REG_TMA:  res.read_data = tma_reg;
                    REG_TAC:  res.read_data = {TAC_READ_ONES, enable_reg, rate_reg};
                    default:  res.read_data = '0;
                endcase
            end
            OP_WRITE:
            begin
                case (req.register_select)
                    REG_DIV:
                    begin
                        step         = enable_reg && sel_bit(counter_reg, rate_reg);
                        counter_next = '0;
                    end
                    REG_TIMA:
                    begin
                        if (stage_reg == STAGE_DELAY)
                        begin
                            tima_next  = req.write_data;
                            stage_next = STAGE_NOW;
                        end
                        else if (stage_reg == STAGE_NOW)
                        begin
                            tima_next  = tma_reg;
                            stage_next = STAGE_OFF;
                        end
                        else
                        begin
                            tima_next = req.write_data;
                        end
                    end
                    REG_TMA:
                    begin
                        tma_next = req.write_data;
                        if (stage_reg == STAGE_NOW)
                            tima_next = req.write_data;
                    end
                    REG_TAC:
                    begin
                        if (enable_reg && !new_en)
                            step = sel_bit(counter_reg, rate_reg);
                        else if (rate_reg != new_rate)
                            step = sel_bit(counter_reg, rate_reg)
                                && !sel_bit(counter_reg, new_rate) && new_en;
                        enable_next = new_en;
                        rate_next   = new_rate;
                    end
                    default:
                    begin
                        step = 1'b0;
                    end
                endcase
            end
            default:
            begin
                step = 1'b0;
            end
        endcase

        // A step from 255 wraps to zero and arms the delayed reload.
        if (step)
        begin
            tima_next = tima_next + 8'd1;
            if (tima_next == 8'd0)
                stage_next = STAGE_DELAY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            enable_reg  <= 1'b0;
            rate_reg    <= '0;
            stage_reg   <= STAGE_OFF;
            tima_reg    <= '0;
            tma_reg     <= '0;
        end
        else if (enable)
        begin
            counter_reg <= counter_next;
            enable_reg  <= enable_next;
            rate_reg    <= rate_next;
            stage_reg   <= stage_next;
            tima_reg    <= tima_next;
            tma_reg     <= tma_next;
        end
    end

endmodule

`default_nettype wire

### verif/tb_divider_timer_counter.sv
// Self-checking testbench for divider_timer_counter: drives ticks, register reads and writes,
// predicts every result with an independent timer model, and checks each response in order.
// Depends on dtc_pkg and the divider_timer_counter RTL.
`timescale 1ns / 1ps

module tb_divider_timer_counter;
    import dtc_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] operation = 2'd0;
    logic [1:0] register_select = 2'd0;
    logic [7:0] write_data = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_data;
    logic       reload_irq;

    logic [15:0] div_count;
    logic        tac_enable;
    logic [1:0]  tac_rate;
    logic [1:0]  reload_phase;
    logic [7:0]  tima_value;
    logic [7:0]  tma_value;

    result_t expected_results[$];
    int      requests_sent = 0;
    int      results_checked = 0;
    int      interrupts_seen = 0;
    int      field_errors = 0;
    bit      no_idle = 1'b0;
    int      result_hold_cycles = 0;
    bit      result_hold_on = 1'b0;

    divider_timer_counter dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .register_select(register_select),
        .write_data(write_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .read_data(read_data),
        .reload_irq(reload_irq)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic watched_bit(input logic [15:0] count, input logic [1:0] rate);
        logic [15:0] mask;
        case (rate)
            2'd0: mask = 16'd512;
            2'd1: mask = 16'd8;
            2'd2: mask = 16'd32;
            default: mask = 16'd128;
        endcase
        return |(count & mask);
    endfunction

    task automatic advance_tima();
        tima_value = tima_value + 8'd1;
        if (tima_value == 8'd0)
            reload_phase = STAGE_DELAY;
    endtask

    task automatic predict_timer(input logic [1:0] op, input logic [1:0] reg_sel,
                                 input logic [7:0] data, output result_t res);
        logic [15:0] prior_count;
        logic        wr_enable;
        logic [1:0]  new_rate;
        res.read_data = 8'h00;
        res.reload_irq = 1'b0;
        case (op)
            OP_TICK:
            begin
                prior_count = div_count;
                div_count = div_count + TICK_INCREMENT;
                if (reload_phase == STAGE_DELAY)
                begin
                    reload_phase = STAGE_NOW;
                    tima_value = tma_value;
                    res.reload_irq = 1'b1;
                end
                else
                    reload_phase = STAGE_OFF;
                if (tac_enable && watched_bit(prior_count, tac_rate)
                    && !watched_bit(div_count, tac_rate))
                    advance_tima();
            end
            OP_READ:
            begin
                case (reg_sel)
                    REG_DIV:  res.read_data = div_count[15:8];
                    REG_TIMA: res.read_data = tima_value;
                    REG_TMA:  res.read_data = tma_value;
                    default:  res.read_data = {TAC_READ_ONES, tac_enable, tac_rate};
                endcase
            end
            OP_WRITE:
            begin
                case (reg_sel)
                    REG_DIV:
                    begin
                        if (tac_enable && watched_bit(div_count, tac_rate))
                            advance_tima();
                        div_count = 16'd0;
                    end
                    REG_TIMA:
                    begin
                        if (reload_phase == STAGE_DELAY)
                        begin
                            tima_value = data;
                            reload_phase = STAGE_NOW;
                        end
                        else if (reload_phase == STAGE_NOW)
                        begin
                            tima_value = tma_value;
                            reload_phase = STAGE_OFF;
                        end
                        else
                            tima_value = data;
                    end
                    REG_TMA:
                    begin
                        tma_value = data;
                        if (reload_phase == STAGE_NOW)
                            tima_value = tma_value;
                    end
                    default:
                    begin
                        wr_enable = data[2];
                        new_rate = data[1:0];
                        if (tac_enable && !wr_enable)
                        begin
                            if (watched_bit(div_count, tac_rate))
                                advance_tima();
                        end
                        else if (tac_rate != new_rate)
                        begin
                            if (watched_bit(div_count, tac_rate)
                                && !watched_bit(div_count, new_rate) && wr_enable)
                                advance_tima();
                        end
                        tac_enable = wr_enable;
                        tac_rate = new_rate;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [1:0] reg_sel,
                                input logic [7:0] data);
        int      gap;
        result_t due;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        register_select <= reg_sel;
        write_data <= data;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_timer(op, reg_sel, data, due);
        expected_results.push_back(due);
        requests_sent++;
    endtask

    task automatic send_tick();
        send_request(OP_TICK, 2'($urandom), 8'($urandom));
    endtask

    task automatic tick_to_overflow();
        while (reload_phase != STAGE_DELAY)
            send_tick();
    endtask

    task automatic drain_results(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (expected_results.size() == 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic poke_timer();
        case ($urandom_range(0, 5))
            0: send_tick();
            1: send_request(OP_WRITE, REG_TIMA, 8'($urandom));
            2: send_request(OP_WRITE, REG_TMA, 8'($urandom));
            3: send_request(OP_WRITE, REG_TAC, 8'($urandom));
            4: send_request(OP_WRITE, REG_DIV, 8'($urandom));
            default: send_request(OP_READ, 2'($urandom), 8'($urandom));
        endcase
    endtask

    task automatic test_reset_values();
        send_request(OP_READ, REG_DIV, 8'h00);
        send_request(OP_READ, REG_TIMA, 8'hFF);
        send_request(OP_READ, REG_TMA, 8'h00);
        send_request(OP_READ, REG_TAC, 8'hFF);
        send_request(OP_UNUSED, REG_TAC, 8'hFF);
    endtask

    task automatic test_overflow_reload();
        send_request(OP_WRITE, REG_DIV, 8'hFF);
        send_request(OP_WRITE, REG_TAC, 8'h05);
        send_request(OP_WRITE, REG_TMA, 8'hFF);
        send_request(OP_WRITE, REG_TIMA, 8'hFF);
        repeat (5) send_tick();
        send_request(OP_READ, REG_TIMA, 8'h00);
    endtask

    task automatic test_pending_reload_writes();
        tick_to_overflow();
        send_request(OP_WRITE, REG_TIMA, 8'h42);
        send_request(OP_WRITE, REG_TIMA, 8'h10);
        tick_to_overflow();
        send_tick();
        send_request(OP_WRITE, REG_TMA, 8'h00);
        send_request(OP_READ, REG_TIMA, 8'h00);
    endtask

    task automatic test_selected_bit_writes();
        send_request(OP_WRITE, REG_DIV, 8'h00);
        repeat (2) send_tick();
        send_request(OP_WRITE, REG_DIV, 8'h00);
        repeat (2) send_tick();
        send_request(OP_WRITE, REG_TAC, 8'h04);
        send_request(OP_WRITE, REG_TAC, 8'h05);
        send_request(OP_WRITE, REG_TAC, 8'h01);
        send_request(OP_READ, REG_TIMA, 8'h00);
        send_request(OP_READ, REG_TAC, 8'h00);
    endtask

    task automatic test_backpressure();
        drain_results(2);
        no_idle = 1'b1;
        result_hold_cycles = 40;
        wait (result_hold_on);
        repeat (6)
        begin
            send_tick();
            send_request(OP_READ, 2'($urandom), 8'($urandom));
        end
        no_idle = 1'b0;
        drain_results(4);
    endtask

    task automatic run_overflow_sequence();
        logic [1:0] rate;
        logic [7:0] start_count;
        int         roll;
        int         n;
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            rate = 2'd1;
            start_count = 8'($urandom_range(248, 255));
        end
        else if (roll < 75)
        begin
            rate = 2'd2;
            start_count = 8'($urandom_range(254, 255));
        end
        else
        begin
            rate = (roll < 90) ? 2'd3 : 2'd0;
            start_count = 8'hFF;
        end
        if ($urandom_range(0, 1))
            send_request(OP_WRITE, REG_DIV, 8'($urandom));
        send_request(OP_WRITE, REG_TAC,
                     {5'($urandom), 1'($urandom_range(0, 7) != 0), rate});
        send_request(OP_WRITE, REG_TMA, 8'($urandom));
        send_request(OP_WRITE, REG_TIMA, start_count);
        n = 0;
        while (tac_enable && reload_phase != STAGE_DELAY && n < 300)
        begin
            send_tick();
            n++;
        end
        if (!tac_enable)
            repeat ($urandom_range(1, 4)) send_tick();
        poke_timer();
        poke_timer();
        repeat ($urandom_range(0, 3)) send_tick();
        send_request(OP_READ, 2'($urandom), 8'($urandom));
    endtask

    task automatic test_random_traffic();
        int first;
        first = requests_sent;
        while (requests_sent - first < 400)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7)
                run_overflow_sequence();
            else
                repeat ($urandom_range(1, 8))
                    send_request(2'($urandom), 2'($urandom), 8'($urandom));
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : result_sink
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if (result_hold_cycles > 0)
            begin
                n = result_hold_cycles;
                result_hold_cycles = 0;
                result_hold_on = 1'b1;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                result_hold_on = 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                n = pick_gap();
                if (n > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : result_checker
        result_t due;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: read_data %0h, interrupt %0b",
                           read_data, reload_irq);
                    field_errors++;
                end
                else
                begin
                    due = expected_results.pop_front();
                    results_checked++;
                    if (reload_irq === 1'b1)
                        interrupts_seen++;
                    if (read_data !== due.read_data)
                    begin
                        $error("read_data: expected %0h, actual %0h", due.read_data, read_data);
                        field_errors++;
                    end
                    if (reload_irq !== due.reload_irq)
                    begin
                        $error("reload_irq: expected %0b, actual %0b",
                               due.reload_irq, reload_irq);
                        field_errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        div_count = 16'd0;
        tac_enable = 1'b0;
        tac_rate = 2'd0;
        reload_phase = STAGE_OFF;
        tima_value = 8'd0;
        tma_value = 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_overflow_reload();
        test_pending_reload_writes();
        test_selected_bit_writes();
        test_backpressure();
        test_random_traffic();
        drain_results(10);

        $display("Sent %0d requests: ticks, reads, writes, unused codes and overflow sequences.",
                 requests_sent);
        $display("Checked %0d results, %0d with the timer interrupt set, %0d field errors.",
                 results_checked, interrupts_seen, field_errors);
        if (field_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
